// ----- hw/rtl/console_bus_address_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Console bus address decoder assertion macros
// Shared concurrent assertion forms for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_BUS_ADDRESS_DECODER_TOP_MACROS_SVH
`define CONSOLE_BUS_ADDRESS_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CBAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbad: assertion failed");

// next-cycle implication, disabled in reset
`define CBAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbad: assertion failed");

`endif

// ----- hw/rtl/cbad_pkg.sv -----
// ----------------------------------------------------------------------------
// cbad_pkg
// Types and constants of the console bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned OFFSET_W = 22;
    localparam int unsigned CYCLES_W = 4;

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_WRAM = 2'd1,
        TGT_SRAM = 2'd2,
        TGT_REG  = 2'd3
    } target_t;

    typedef enum logic {
        CFG_MAPPER_MODE = 1'b0,
        CFG_FAST_ROM    = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MAP_LOROM = 1'b0,
        MAP_HIROM = 1'b1
    } mapper_t;

    localparam logic CMD_WRITE = 1'b1;

    localparam logic [CYCLES_W-1:0] CYC_SLOW = 4'd8;
    localparam logic [CYCLES_W-1:0] CYC_FAST = 4'd6;
    localparam logic [CYCLES_W-1:0] CYC_NONE = 4'd0;

    typedef struct packed {
        target_t                     target;
        logic [OFFSET_W-1:0]         store_offset;
        logic                        write_effective;
        logic [CYCLES_W-1:0]         access_cycles;
    } result_t;

endpackage

// ----- hw/rtl/console_bus_address_decoder_top.sv -----
// ----------------------------------------------------------------------------
// console_bus_address_decoder_top
// Decodes one 24-bit console bus access per transaction into target store,
// offset, write effect and master-cycle cost (LoROM or HiROM mapping).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries cmd, bus_address and
//   dma_active; response channel (rsp_valid/rsp_stall) carries target,
//   store_offset, write_effective and access_cycles. A transaction moves at
//   a clock edge with valid high and stall low.
//   Path: a request passes the input register, the combinational decode and
//   the result register, which loads only when empty or being taken.
//   Throughput: 1 transaction per cycle while the response is not stalled; the two register stages advance
//   together whenever the result register is empty or being taken.
//   Stall: a stalled response holds; the input register still takes one
//   more request, then req_stall rises until the response is taken.
//   Config: cfg_write_enable with cfg_index (0 mapper_mode, 1 fast ROM enable)
//   and cfg_data; write only while no transaction is in flight (not enforced).
//   Reset: both stages empty, mapper LoROM, fast ROM off.
// ----------------------------------------------------------------------------
module console_bus_address_decoder_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_enable,
    input  logic                              cfg_index,
    input  logic                              cfg_data,

    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              cmd,
    input  logic [cbad_pkg::ADDR_W-1:0]       bus_address,
    input  logic                              dma_active,

    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [1:0]                        target,
    output logic [cbad_pkg::OFFSET_W-1:0]     store_offset,
    output logic                              write_effective,
    output logic [cbad_pkg::CYCLES_W-1:0]     access_cycles
);

    logic                              mapper_mode_reg;
    logic                              fast_rom_reg;

    logic                              s1_valid_reg;
    logic                              s1_cmd_reg;
    logic [cbad_pkg::ADDR_W-1:0]       s1_addr_reg;
    logic                              s1_dma_reg;

    logic                              rsp_valid_reg;
    cbad_pkg::result_t                 result_reg;
    cbad_pkg::result_t                 result_next;

    logic                              rsp_ready;
    logic                              s1_ready;
    logic                              req_take;

    logic [7:0]                        bank;
    logic [2:0]                        page;
    logic                              upper;
    logic                              hirom;
    logic [cbad_pkg::OFFSET_W-1:0]     rom_offset;
    logic                              wr;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_mode_reg <= 1'b0;
            fast_rom_reg    <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cbad_pkg::cfg_index_t'(cfg_index))
                cbad_pkg::CFG_MAPPER_MODE: mapper_mode_reg <= cfg_data;
                cbad_pkg::CFG_FAST_ROM:    fast_rom_reg    <= cfg_data;
                default:                   mapper_mode_reg <= mapper_mode_reg;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign rsp_ready = !rsp_valid_reg || !rsp_stall;
    assign s1_ready  = !s1_valid_reg || rsp_ready;
    assign req_stall = !s1_ready;
    assign req_take  = req_valid && s1_ready;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= bus_address;
            s1_dma_reg  <= dma_active;
        end
    end

    // ---------------- decode ----------------
    assign bank  = s1_addr_reg[23:16];
    assign page  = s1_addr_reg[15:13];
    assign upper = bank[7];
    assign hirom = (cbad_pkg::mapper_t'(mapper_mode_reg) == cbad_pkg::MAP_HIROM);
    assign wr    = (s1_cmd_reg == cbad_pkg::CMD_WRITE);

    assign rom_offset = hirom ? s1_addr_reg[21:0]
                              : {s1_addr_reg[22:16], s1_addr_reg[14:0]};

    always_comb
    begin
        result_next.target       = cbad_pkg::TGT_ROM;
        result_next.store_offset = rom_offset;

        if (!bank[6])
        begin
            // system banks 00-3f / 80-bf
            if (page == 3'd0)
            begin
                result_next.target       = cbad_pkg::TGT_WRAM;
                result_next.store_offset = {9'd0, s1_addr_reg[12:0]};
            end
            else if (page == 3'd3 && hirom && bank[5])
            begin
                result_next.target       = cbad_pkg::TGT_SRAM;
                result_next.store_offset = {9'd0, s1_addr_reg[12:0]};
            end
            else if (!page[2])
            begin
                result_next.target       = cbad_pkg::TGT_REG;
                result_next.store_offset = {6'd0, s1_addr_reg[15:0]};
            end
        end
        else if (bank[7:1] == 7'h3f)
        begin
            // banks 7e-7f
            result_next.target       = cbad_pkg::TGT_WRAM;
            result_next.store_offset = {5'd0, s1_addr_reg[16:0]};
        end
        else if (!hirom && !page[2] && bank[6:4] == 3'b111)
        begin
            result_next.target       = cbad_pkg::TGT_SRAM;
            result_next.store_offset = {9'd0, s1_addr_reg[12:0]};
        end

        unique case (result_next.target)
            cbad_pkg::TGT_REG:
            begin
                result_next.access_cycles   = cbad_pkg::CYC_NONE;
                result_next.write_effective = wr;
            end
            cbad_pkg::TGT_ROM:
            begin
                result_next.write_effective = 1'b0;
                if (wr)
                    result_next.access_cycles = cbad_pkg::CYC_NONE;
                else if (upper && fast_rom_reg && !s1_dma_reg)
                    result_next.access_cycles = cbad_pkg::CYC_FAST;
                else
                    result_next.access_cycles = cbad_pkg::CYC_SLOW;
            end
            default:
            begin
                result_next.access_cycles   = cbad_pkg::CYC_SLOW;
                result_next.write_effective = wr;
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign target          = result_reg.target;
    assign store_offset    = result_reg.store_offset;
    assign write_effective = result_reg.write_effective;
    assign access_cycles   = result_reg.access_cycles;

endmodule

// ----- hw/rtl/cbad_checker.sv -----
// ----------------------------------------------------------------------------
// cbad_checker
// Port-level checks of the console bus address decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "console_bus_address_decoder_top_macros.svh"

module cbad_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_stall,
    input  logic                              cmd,
    input  logic [cbad_pkg::ADDR_W-1:0]       bus_address,
    input  logic                              dma_active,
    input  logic                              rsp_valid,
    input  logic                              rsp_stall,
    input  logic [1:0]                        target,
    input  logic [cbad_pkg::OFFSET_W-1:0]     store_offset,
    input  logic                              write_effective,
    input  logic [cbad_pkg::CYCLES_W-1:0]     access_cycles
);

    logic                                                rsp_reg_bus;
    logic                                                rsp_fast;
    logic                                                rsp_ram;
    logic                                                rsp_wait;
    logic                                                req_wait;
    logic [cbad_pkg::OFFSET_W+cbad_pkg::CYCLES_W+2:0]    rsp_word;
    logic [cbad_pkg::ADDR_W+1:0]                         req_word;

    assign rsp_reg_bus = rsp_valid && target == cbad_pkg::TGT_REG;
    assign rsp_fast    = rsp_valid && access_cycles == cbad_pkg::CYC_FAST;
    assign rsp_ram     = rsp_valid && (target == cbad_pkg::TGT_WRAM ||
                                       target == cbad_pkg::TGT_SRAM);
    assign rsp_wait    = rsp_valid && rsp_stall;
    assign req_wait    = req_valid && req_stall;
    assign rsp_word    = {target, store_offset, write_effective, access_cycles};
    assign req_word    = {cmd, bus_address, dma_active};

    `CBAD_ASSERT_NOW(a_reg_bus_free, rsp_reg_bus, access_cycles == cbad_pkg::CYC_NONE)

    `CBAD_ASSERT_NOW(a_fast_only_rom_read, rsp_fast, target == cbad_pkg::TGT_ROM && !write_effective)

    `CBAD_ASSERT_NOW(a_ram_slow, rsp_ram, access_cycles == cbad_pkg::CYC_SLOW)

    `CBAD_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_word))

    `CBAD_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(req_word))

endmodule

bind console_bus_address_decoder_top cbad_checker u_cbad_checker (.*);
